### hw/rtl/sle_pkg.sv
// Shared types and codes for the sorted list engine.
// Holds the request and result payloads and the control word passed along the cell chain.
// No dependencies.
package sle_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam int VALUE_FIELD_W = 32;
  localparam int POSITION_W    = 4;
  localparam int COUNT_W       = 5;

  typedef struct packed {
    logic [1:0]                      opcode;
    logic signed [VALUE_FIELD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [POSITION_W-1:0] position;
    logic [COUNT_W-1:0]    entry_count;
  } out_t;

  typedef struct packed {
    logic       active;
    logic [1:0] op;
    logic       full;
    logic       hit;
  } wave_ctl_t;

endpackage

### hw/rtl/sle_cell.sv
// One cell of the sorted list chain: holds one entry and passes the request wave on.
// Depends on sle_pkg for the control word and opcodes.
// Instantiated by sorted_list_engine_top.
module sle_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int DEPTH       = 16,
  parameter int IDX         = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(DEPTH+1)-1:0]          count_i,
  input  sle_pkg::wave_ctl_t                  ctl_i,
  input  logic signed [VALUE_WIDTH-1:0]       key_i,
  input  logic signed [VALUE_WIDTH-1:0]       carry_i,
  input  logic [$clog2(DEPTH)-1:0]            pos_i,
  input  logic signed [VALUE_WIDTH-1:0]       next_entry_i,
  output logic signed [VALUE_WIDTH-1:0]       entry_o,
  output sle_pkg::wave_ctl_t                  ctl_o,
  output logic signed [VALUE_WIDTH-1:0]       key_o,
  output logic signed [VALUE_WIDTH-1:0]       carry_o,
  output logic [$clog2(DEPTH)-1:0]            pos_o
);
  import sle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_P = IW'(IDX);

  logic signed [VALUE_WIDTH-1:0] entry_r, entry_nxt;
  logic signed [VALUE_WIDTH-1:0] key_r, carry_r, carry_nxt;
  logic [IW-1:0]                 pos_r, pos_nxt;
  wave_ctl_t                     ctl_r, ctl_nxt;

  logic valid;
  logic in_reach;
  logic is_insert;
  logic is_lookup;
  logic take_ins;
  logic match;

  always_comb begin
    valid     = IDX_C < count_i;
    in_reach  = IDX_C <= count_i;
    is_insert = ctl_i.active && (ctl_i.op == OP_INSERT) && !ctl_i.full;
    is_lookup = ctl_i.active && ((ctl_i.op == OP_REMOVE) || (ctl_i.op == OP_SEARCH));
    take_ins  = is_insert && in_reach && (ctl_i.hit || !valid || (entry_r >= key_i));
    match     = is_lookup && valid && !ctl_i.hit && (entry_r == key_i);

    entry_nxt = entry_r;
    carry_nxt = carry_i;
    pos_nxt   = pos_i;
    ctl_nxt   = ctl_i;

    if (take_ins) begin
      entry_nxt   = carry_i;
      carry_nxt   = entry_r;
      ctl_nxt.hit = 1'b1;
      if (!ctl_i.hit) begin
        pos_nxt = IDX_P;
      end
    end

    if (match) begin
      ctl_nxt.hit = 1'b1;
      pos_nxt     = IDX_P;
    end

    if (is_lookup && (ctl_i.op == OP_REMOVE) && valid && (ctl_i.hit || match)) begin
      entry_nxt = next_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    entry_r <= entry_nxt;
    key_r   <= key_i;
    carry_r <= carry_nxt;
    pos_r   <= pos_nxt;
  end

  assign entry_o = entry_r;
  assign ctl_o   = ctl_r;
  assign key_o   = key_r;
  assign carry_o = carry_r;
  assign pos_o   = pos_r;

endmodule

### hw/rtl/sorted_list_engine_top.sv
// Top level of the sorted list engine: request intake, cell chain, result register.
// Depends on sle_pkg and sle_cell.
// Each request travels the cell chain as a wave, one cell per clock.
//
// The engine keeps up to DEPTH signed values in ascending order and serves insert,
// remove-first-equal and search requests one at a time. A request travels the row of
// DEPTH cells one cell per clock, then the result register. in_ready returns high
// in the cycle after the result is formed if the output register is free; else the
// result waits in a hold register and in_ready stays low until it moves on. The
// result register lets a new request start while the last result waits on out_ready.
module sorted_list_engine_top #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sle_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sle_pkg::out_t out_data
);
  import sle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  wave_ctl_t                     ctl_w   [DEPTH+1];
  logic signed [VALUE_WIDTH-1:0] key_w   [DEPTH+1];
  logic signed [VALUE_WIDTH-1:0] carry_w [DEPTH+1];
  logic [IW-1:0]                 pos_w   [DEPTH+1];
  logic signed [VALUE_WIDTH-1:0] entry_w [DEPTH+1];

  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r;
  logic          hold_valid_r;
  out_t          hold_r;
  logic          out_valid_r;
  out_t          out_r;

  logic      accept;
  logic      done;
  logic      out_free;
  wave_ctl_t last;
  out_t      res;

  assign in_ready = !busy_r && !hold_valid_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl_w[0].active = accept;
    ctl_w[0].op     = in_data.opcode;
    ctl_w[0].full   = count_r == DEPTH_C;
    ctl_w[0].hit    = 1'b0;
    key_w[0]        = VALUE_WIDTH'(in_data.value);
    carry_w[0]      = VALUE_WIDTH'(in_data.value);
    pos_w[0]        = '0;
    entry_w[DEPTH]  = '0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sle_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .DEPTH      (DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .count_i     (count_r),
      .ctl_i       (ctl_w[i]),
      .key_i       (key_w[i]),
      .carry_i     (carry_w[i]),
      .pos_i       (pos_w[i]),
      .next_entry_i(entry_w[i+1]),
      .entry_o     (entry_w[i]),
      .ctl_o       (ctl_w[i+1]),
      .key_o       (key_w[i+1]),
      .carry_o     (carry_w[i+1]),
      .pos_o       (pos_w[i+1])
    );
  end

  always_comb begin
    last      = ctl_w[DEPTH];
    done      = last.active;
    count_nxt = count_r;
    res       = '0;
    unique case (last.op)
      OP_INSERT: begin
        if (last.full) begin
          res.status = ST_FULL;
        end else begin
          res.status   = ST_OK;
          res.position = POSITION_W'(pos_w[DEPTH]);
          count_nxt    = count_r + ONE_C;
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (last.hit) begin
          res.status   = ST_OK;
          res.found    = 1'b1;
          res.position = POSITION_W'(pos_w[DEPTH]);
          if (last.op == OP_REMOVE) begin
            count_nxt = count_r - ONE_C;
          end
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.entry_count = COUNT_W'(count_nxt);
    out_free        = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      busy_r       <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (done) begin
        busy_r  <= 1'b0;
        count_r <= count_nxt;
        if (out_free) begin
          out_valid_r <= 1'b1;
        end else begin
          hold_valid_r <= 1'b1;
        end
      end else if (hold_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (done) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        hold_r <= res;
      end
    end else if (hold_valid_r && out_free) begin
      out_r <= hold_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
